### rtl/core/frt_pkg.sv
// Shared types and constants for the fragment reassembly tracker.
// Holds field widths, status codes, register indexes and the item and result structs.
// Depends on nothing.
package frt_pkg;

  // Fixed field widths of the fragment header and of the result.
  localparam int FILE_W   = 10;
  localparam int FRAG_W   = 7;
  localparam int FLEN_W   = 10;
  localparam int TLEN_W   = 17;
  localparam int OFS_W    = 17;
  localparam int BYTES_W  = 17;
  localparam int DONE_W   = 11;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 1;

  // Saturation limits of the offset and of the done counter.
  localparam logic [OFS_W-1:0]  OFFSET_MAX = 17'h1FFFF;
  localparam logic [DONE_W-1:0] DONE_MAX   = 11'h7FF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FILE_COUNT      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAGMENT_STRIDE = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] FILE_COUNT_RESET      = 11'd0;
  localparam logic [CFG_W-1:0] FRAGMENT_STRIDE_RESET = 11'd1024;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_IGNORED  = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_ACCEPTED = 2'd2,
    ST_COMPLETE = 2'd3
  } frt_status_t;

  // A classified fragment header as handed from the front to the back.
  typedef struct packed {
    logic [FILE_W-1:0] file_index;
    logic [FRAG_W-1:0] frag_index;
    logic [FLEN_W-1:0] frag_length;
    logic [TLEN_W-1:0] file_length;
    logic [FLEN_W-1:0] payload_length;
    logic              file_ok;
    logic              frag_ok;
    logic [OFS_W-1:0]  buffer_offset;
  } frt_item_t;

  // One result as held in the result queue.
  typedef struct packed {
    frt_status_t        status;
    logic [FILE_W-1:0]  file_echo;
    logic [OFS_W-1:0]   buffer_offset;
    logic [BYTES_W-1:0] bytes_received;
    logic [DONE_W-1:0]  files_done;
    logic               all_done;
  } frt_result_t;

endpackage

### rtl/core/fragment_reassembly_tracker_core.sv
// Fragment reassembly tracker, top level: configuration registers, front end and back end.
// Each header goes through the item queue, the row read and the row update into the result queue.
// A new header is taken only after the last one's row is written and while results have room.
// Reset: synchronous, active high; afterwards the table is cleared one file row per cycle, up to
// MAX_FILES rows (at most 1024), with full held high. Depends on frt_pkg, frt_front, frt_back.
module fragment_reassembly_tracker_core
  import frt_pkg::*;
#(
  parameter int MAX_FILES = 1024,
  parameter int MAX_FRAGS = 128,
  parameter int LEN_BITS  = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 push,
  output logic                 full,
  input  logic [FILE_W-1:0]    file_index,
  input  logic [FRAG_W-1:0]    frag_index,
  input  logic [FLEN_W-1:0]    frag_length,
  input  logic [TLEN_W-1:0]    file_length,
  input  logic [FLEN_W-1:0]    payload_length,
  input  logic                 pop,
  output logic                 empty,
  output logic [1:0]           status,
  output logic [FILE_W-1:0]    file_echo,
  output logic [OFS_W-1:0]     buffer_offset,
  output logic [BYTES_W-1:0]   bytes_received,
  output logic [DONE_W-1:0]    files_done,
  output logic                 all_done
);

  logic [CFG_W-1:0] file_count;
  logic [CFG_W-1:0] fragment_stride;
  frt_item_t        item;
  logic             item_empty;
  logic             item_pop;
  logic             clearing;
  frt_result_t      res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      file_count      <= FILE_COUNT_RESET;
      fragment_stride <= FRAGMENT_STRIDE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FILE_COUNT:      file_count      <= cfg_data;
        REG_FRAGMENT_STRIDE: fragment_stride <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  frt_front #(
    .MAX_FILES (MAX_FILES),
    .MAX_FRAGS (MAX_FRAGS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .hold            (clearing),
    .file_index      (file_index),
    .frag_index      (frag_index),
    .frag_length     (frag_length),
    .file_length     (file_length),
    .payload_length  (payload_length),
    .fragment_stride (fragment_stride),
    .item_pop        (item_pop),
    .item            (item),
    .item_empty      (item_empty)
  );

  frt_back #(
    .MAX_FILES (MAX_FILES),
    .MAX_FRAGS (MAX_FRAGS),
    .LEN_BITS  (LEN_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .file_count (file_count),
    .clearing   (clearing),
    .res_pop    (pop),
    .res        (res),
    .res_empty  (empty)
  );

  assign status         = res.status;
  assign file_echo      = res.file_echo;
  assign buffer_offset  = res.buffer_offset;
  assign bytes_received = res.bytes_received;
  assign files_done     = res.files_done;
  assign all_done       = res.all_done;

endmodule

### rtl/core/frt_queue.sv
// Small first-in first-out queue of fixed-width words.
// Used between the front and the back and for the results; depends on nothing.
module frt_queue #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

### rtl/core/frt_front.sv
// Front end of the tracker: accepts fragment headers, checks index ranges and
// computes the buffer offset, then queues the classified item. Uses frt_pkg, frt_queue.
module frt_front
  import frt_pkg::*;
#(
  parameter int MAX_FILES = 1024,
  parameter int MAX_FRAGS = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              hold,
  input  logic [FILE_W-1:0] file_index,
  input  logic [FRAG_W-1:0] frag_index,
  input  logic [FLEN_W-1:0] frag_length,
  input  logic [TLEN_W-1:0] file_length,
  input  logic [FLEN_W-1:0] payload_length,
  input  logic [CFG_W-1:0]  fragment_stride,
  input  logic              item_pop,
  output frt_item_t         item,
  output logic              item_empty
);

  localparam int PROD_W = FRAG_W + CFG_W;

  frt_item_t         item_in;
  logic [PROD_W-1:0] product;
  logic              q_full;
  logic              q_wr;
  logic [$bits(frt_item_t)-1:0] q_rd_data;

  // Offset is the fragment slot times the stride, saturated to the field width.
  assign product = PROD_W'(frag_index) * PROD_W'(fragment_stride);

  always_comb begin
    item_in.file_index     = file_index;
    item_in.frag_index     = frag_index;
    item_in.frag_length    = frag_length;
    item_in.file_length    = file_length;
    item_in.payload_length = payload_length;
    item_in.file_ok        = (32'(file_index) < 32'(MAX_FILES));
    item_in.frag_ok        = (32'(frag_index) < 32'(MAX_FRAGS));
    if (product > PROD_W'(OFFSET_MAX)) begin
      item_in.buffer_offset = OFFSET_MAX;
    end else begin
      item_in.buffer_offset = product[OFS_W-1:0];
    end
  end

  // No transaction is taken while the back clears its table.
  assign full = q_full || hold;
  assign q_wr = push && !full;

  frt_queue #(
    .DEPTH (2),
    .WIDTH ($bits(frt_item_t))
  ) u_item_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (item_in),
    .rd_en   (item_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (item_empty)
  );

  assign item = frt_item_t'(q_rd_data);

endmodule

### rtl/core/frt_back.sv
// Back end of the tracker: per-file table with a read-modify-write sequencer,
// the done counter, the clearing pass after reset and the result queue.
// Uses frt_pkg and frt_queue.
module frt_back
  import frt_pkg::*;
#(
  parameter int MAX_FILES = 1024,
  parameter int MAX_FRAGS = 128,
  parameter int LEN_BITS  = 17
) (
  input  logic        clk,
  input  logic        rst,
  input  frt_item_t   item,
  input  logic        item_empty,
  output logic        item_pop,
  input  logic [CFG_W-1:0] file_count,
  output logic        clearing,
  input  logic        res_pop,
  output frt_result_t res,
  output logic        res_empty
);

  // Only as many files and fragment slots as the index fields can reach are stored.
  localparam int FILE_DEPTH = (MAX_FILES < (1 << FILE_W)) ? MAX_FILES : (1 << FILE_W);
  localparam int FRAG_SLOTS = (MAX_FRAGS < (1 << FRAG_W)) ? MAX_FRAGS : (1 << FRAG_W);
  localparam int FILE_AW    = $clog2(FILE_DEPTH);
  localparam int FRAG_IW    = $clog2(FRAG_SLOTS);
  localparam int SUM_W      = ((LEN_BITS > FLEN_W) ? LEN_BITS : FLEN_W) + 1;
  localparam int WORD_W     = 1 + LEN_BITS + FRAG_SLOTS;
  localparam logic [SUM_W-1:0] LEN_MAX = SUM_W'((64'd1 << LEN_BITS) - 64'd1);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [FILE_AW-1:0]   clr_addr;
  logic [DONE_W-1:0]    done_total;
  logic [DONE_W-1:0]    done_total_next;
  frt_item_t            cur;
  logic [WORD_W-1:0]    mem [FILE_DEPTH];
  logic [WORD_W-1:0]    rd_word;
  logic                 mem_we;
  logic [FILE_AW-1:0]   mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;
  logic                 start;

  logic [FRAG_SLOTS-1:0] seen_row;
  logic [LEN_BITS-1:0]   rcv;
  logic                  fin;
  logic [FRAG_IW-1:0]    slot;
  logic                  take;
  logic                  match;
  logic [SUM_W-1:0]      sum;
  logic [LEN_BITS-1:0]   new_rcv;
  logic [LEN_BITS-1:0]   total;
  logic                  complete;
  logic                  commit;
  logic [LEN_BITS-1:0]   bytes_len;
  logic [31:0]           bytes_wide;
  frt_result_t           res_in;
  logic                  res_push;
  logic                  res_full;
  logic [$bits(frt_result_t)-1:0] res_rd_data;

  assign clearing = (state == S_CLEAR);
  assign start    = (state == S_IDLE) && !item_empty && !res_full;
  assign item_pop = start;

  // Sequencer: clear the table once, then take one item, read its row, update it.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == FILE_AW'(FILE_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      done_total <= '0;
    end else begin
      state      <= state_next;
      done_total <= done_total_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // The item under work is latched when its row read is issued.
  always_ff @(posedge clk) begin
    if (start) begin
      cur <= item;
    end
  end

  // Row update for the item under work.
  always_comb begin
    seen_row = rd_word[FRAG_SLOTS-1:0];
    rcv      = rd_word[FRAG_SLOTS +: LEN_BITS];
    fin      = rd_word[WORD_W-1];
    slot     = cur.frag_index[FRAG_IW-1:0];
    take     = cur.file_ok && cur.frag_ok && !fin && !seen_row[slot];
    match    = (cur.payload_length == cur.frag_length);
    sum      = SUM_W'(rcv) + SUM_W'(cur.frag_length);
    new_rcv  = (sum > LEN_MAX) ? LEN_MAX[LEN_BITS-1:0] : sum[LEN_BITS-1:0];
    // The stored total is only ever compared in the step that writes it.
    total    = LEN_BITS'(cur.file_length);
    complete = (new_rcv >= total);
    commit   = (state == S_EXEC) && take && match;
  end

  // Done counter saturates at its top value.
  always_comb begin
    done_total_next = done_total;
    if (commit && complete && (done_total < DONE_MAX)) begin
      done_total_next = done_total + 1'b1;
    end
  end

  // Table write port: zeros during the clearing pass, otherwise the updated row when an item commits.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur.file_index[FILE_AW-1:0];
    mem_wdata = {complete, new_rcv, seen_row | (FRAG_SLOTS'(1) << slot)};
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (commit) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (start) begin
      rd_word <= mem[item.file_index[FILE_AW-1:0]];
    end
  end

  // Result assembly.
  always_comb begin
    if (!cur.file_ok) begin
      bytes_len = '0;
    end else if (take && match) begin
      bytes_len = new_rcv;
    end else begin
      bytes_len = rcv;
    end
    bytes_wide = 32'(bytes_len);

    if (!take) begin
      res_in.status = ST_IGNORED;
    end else if (!match) begin
      res_in.status = ST_DROPPED;
    end else if (complete) begin
      res_in.status = ST_COMPLETE;
    end else begin
      res_in.status = ST_ACCEPTED;
    end
    res_in.file_echo      = cur.file_index;
    res_in.buffer_offset  = cur.buffer_offset;
    res_in.bytes_received = bytes_wide[BYTES_W-1:0];
    res_in.files_done     = done_total_next;
    res_in.all_done       = (done_total_next >= file_count);
  end

  assign res_push = (state == S_EXEC);

  frt_queue #(
    .DEPTH (2),
    .WIDTH ($bits(frt_result_t))
  ) u_result_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .rd_en   (res_pop),
    .rd_data (res_rd_data),
    .full    (res_full),
    .empty   (res_empty)
  );

  assign res = frt_result_t'(res_rd_data);

endmodule

### tb/tb_fragment_reassembly_tracker_core.sv
// Self-checking testbench for fragment_reassembly_tracker_core: directed cases, a back-pressure run
// and randomized file transfers, each result checked against a fragment tracking predictor.
// Depends on frt_pkg and the fragment_reassembly_tracker_core RTL.
`timescale 1ns / 100ps

module tb_fragment_reassembly_tracker_core;
  import frt_pkg::*;

  localparam int BYTES_LIMIT = (1 << BYTES_W) - 1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 push = 1'b0;
  logic                 full;
  logic [FILE_W-1:0]    file_index = '0;
  logic [FRAG_W-1:0]    frag_index = '0;
  logic [FLEN_W-1:0]    frag_length = '0;
  logic [TLEN_W-1:0]    file_length = '0;
  logic [FLEN_W-1:0]    payload_length = '0;
  logic                 pop = 1'b0;
  logic                 empty;
  logic [1:0]           status;
  logic [FILE_W-1:0]    file_echo;
  logic [OFS_W-1:0]     buffer_offset;
  logic [BYTES_W-1:0]   bytes_received;
  logic [DONE_W-1:0]    files_done;
  logic                 all_done;

  fragment_reassembly_tracker_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .file_index(file_index),
    .frag_index(frag_index),
    .frag_length(frag_length),
    .file_length(file_length),
    .payload_length(payload_length),
    .pop(pop),
    .empty(empty),
    .status(status),
    .file_echo(file_echo),
    .buffer_offset(buffer_offset),
    .bytes_received(bytes_received),
    .files_done(files_done),
    .all_done(all_done)
  );

  // Tracker state as the predictor sees it.
  bit [127:0]         frag_seen [1024];
  bit [BYTES_W-1:0]   file_bytes [1024];
  bit                 file_complete [1024];
  bit [DONE_W-1:0]    done_count = '0;
  logic [CFG_W-1:0]   file_goal = FILE_COUNT_RESET;
  logic [CFG_W-1:0]   slot_stride = FRAGMENT_STRIDE_RESET;

  // Predicted verdicts in header order, and run bookkeeping.
  frt_result_t predicted_verdicts[$];
  int mismatch_count = 0;
  int useful_items = 0;
  int sender_mode = 1;
  int recv_mode = 1;
  int hold_cycles = 0;
  int pop_pause = 0;

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random idle length: none in mode 0; otherwise mostly none or short, now and then long.
  function automatic int pick_gap(int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Predict the verdict for one fragment header and update the tracker state.
  function automatic frt_result_t track_fragment(logic [FILE_W-1:0] fi, logic [FRAG_W-1:0] gi,
                                                 logic [FLEN_W-1:0] flen, logic [TLEN_W-1:0] tlen,
                                                 logic [FLEN_W-1:0] plen);
    frt_result_t verdict;
    logic [31:0] ofs;
    logic [31:0] sum;
    ofs = 32'(gi) * 32'(slot_stride);
    if (ofs > 32'(OFFSET_MAX)) ofs = 32'(OFFSET_MAX);
    verdict.status = ST_IGNORED;
    if (!file_complete[fi] && !frag_seen[fi][gi]) begin
      if (plen != flen) begin
        verdict.status = ST_DROPPED;
      end else begin
        frag_seen[fi][gi] = 1'b1;
        sum = 32'(file_bytes[fi]) + 32'(flen);
        if (sum > BYTES_LIMIT) sum = BYTES_LIMIT;
        file_bytes[fi] = sum[BYTES_W-1:0];
        verdict.status = ST_ACCEPTED;
        // The stored total is the one this header just wrote.
        if (file_bytes[fi] >= tlen) begin
          file_complete[fi] = 1'b1;
          if (done_count != DONE_MAX) done_count = done_count + 1'b1;
          verdict.status = ST_COMPLETE;
        end
      end
    end
    verdict.file_echo = fi;
    verdict.buffer_offset = ofs[OFS_W-1:0];
    verdict.bytes_received = file_bytes[fi];
    verdict.files_done = done_count;
    verdict.all_done = (done_count >= file_goal);
    return verdict;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
  endtask

  // Send one header transaction after a random gap, then predict its verdict.
  task automatic send_fragment(logic [FILE_W-1:0] fi, logic [FRAG_W-1:0] gi,
                               logic [FLEN_W-1:0] flen, logic [TLEN_W-1:0] tlen,
                               logic [FLEN_W-1:0] plen);
    int gap;
    frt_result_t verdict;
    gap = pick_gap(sender_mode);
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    file_index <= fi;
    frag_index <= gi;
    frag_length <= flen;
    file_length <= tlen;
    payload_length <= plen;
    @(posedge clk);
    while (full) @(posedge clk);
    verdict = track_fragment(fi, gi, flen, tlen, plen);
    predicted_verdicts.push_back(verdict);
    if (verdict.status != ST_IGNORED) useful_items++;
  endtask

  // Write one configuration register; only called while the block is idle.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_FILE_COUNT) file_goal = value;
    else slot_stride = value;
  endtask

  // Stop offering headers and wait until every verdict has come back, plus the latency.
  task automatic wait_results_drained();
    @(negedge clk);
    push <= 1'b0;
    @(posedge clk);
    while (predicted_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Pick a file that has seen no fragment yet, if one turns up quickly.
  function automatic logic [FILE_W-1:0] pick_fresh_file();
    logic [FILE_W-1:0] f;
    f = FILE_W'($urandom_range(0, 1023));
    for (int t = 0; t < 64; t++) begin
      if (!file_complete[f] && file_bytes[f] == 0 && frag_seen[f] == '0) return f;
      f = FILE_W'($urandom_range(0, 1023));
    end
    return f;
  endfunction

  // Send a whole file as n fragments in random slots, with occasional bad lengths,
  // repeated fragments and a header total that is too large or too small.
  task automatic send_file(int n, int max_len);
    logic [FRAG_W-1:0] slots[$];
    logic [FLEN_W-1:0] lens[$];
    bit [127:0]        taken;
    logic [FRAG_W-1:0] s;
    logic [FILE_W-1:0] fi;
    logic [TLEN_W-1:0] claim;
    logic [FLEN_W-1:0] bad_len;
    int total;
    int r;
    fi = pick_fresh_file();
    taken = '0;
    total = 0;
    for (int k = 0; k < n; k++) begin
      do s = FRAG_W'($urandom_range(0, 127)); while (taken[s]);
      taken[s] = 1'b1;
      slots.push_back(s);
      lens.push_back(FLEN_W'($urandom_range(0, max_len)));
      total += lens[k];
    end
    r = $urandom_range(0, 9);
    claim = TLEN_W'(total);
    if (r == 0) claim = TLEN_W'(total + $urandom_range(1, 120));
    else if (r == 1 && total > 0) claim = TLEN_W'($urandom_range(0, total - 1));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        bad_len = lens[k] ^ FLEN_W'($urandom_range(1, 1023));
        send_fragment(fi, slots[k], lens[k], claim, bad_len);
      end
      send_fragment(fi, slots[k], lens[k], claim, lens[k]);
      if ($urandom_range(0, 9) == 0) send_fragment(fi, slots[k], lens[k], claim, lens[k]);
    end
  endtask

  // One header with random content, half of them with a matching payload length.
  task automatic send_noise();
    logic [FLEN_W-1:0] flen;
    logic [FLEN_W-1:0] plen;
    flen = FLEN_W'($urandom_range(0, 1023));
    plen = ($urandom_range(0, 1) == 0) ? flen : FLEN_W'($urandom_range(0, 1023));
    send_fragment(FILE_W'($urandom_range(0, 1023)), FRAG_W'($urandom_range(0, 127)), flen,
                  TLEN_W'($urandom_range(0, 131071)), plen);
  endtask

  // Field extremes, every status and the special cases under extreme settings.
  task automatic test_directed_cases();
    write_register(REG_FILE_COUNT, 11'd2);
    write_register(REG_FRAGMENT_STRIDE, 11'd1024);
    // A zero total length completes on the first accepted fragment.
    send_fragment(10'd0, 7'd0, 10'd0, 17'd0, 10'd0);
    send_fragment(10'd0, 7'd5, 10'd3, 17'd3, 10'd3);
    send_fragment(10'd1023, 7'd127, 10'd1023, 17'd131071, 10'd1023);
    send_fragment(10'd1023, 7'd127, 10'd1023, 17'd131071, 10'd1023);
    send_fragment(10'd1023, 7'd1, 10'd1023, 17'd2046, 10'd0);
    send_fragment(10'd1023, 7'd1, 10'd0, 17'd2046, 10'd1023);
    // This one completes the file and brings the done count to the file count.
    send_fragment(10'd1023, 7'd1, 10'd1023, 17'd2046, 10'd1023);
    send_fragment(10'd1023, 7'd2, 10'd10, 17'd2046, 10'd10);
    send_fragment(10'd512, 7'd64, 10'd0, 17'd100, 10'd0);
    // A seen slot is ignored before its payload length is looked at.
    send_fragment(10'd512, 7'd64, 10'd0, 17'd100, 10'd5);
    // Received bytes passing the total also complete the file.
    send_fragment(10'd512, 7'd65, 10'd700, 17'd600, 10'd700);
    wait_results_drained();

    // Widest stride saturates the offset; zero file count keeps all_done high.
    write_register(REG_FRAGMENT_STRIDE, 11'd2047);
    write_register(REG_FILE_COUNT, 11'd0);
    send_fragment(10'd341, 7'd64, 10'd682, 17'd85000, 10'd682);
    send_fragment(10'd341, 7'd65, 10'd341, 17'd85000, 10'd341);
    send_fragment(10'd341, 7'd127, 10'd5, 17'd85000, 10'd6);
    wait_results_drained();

    write_register(REG_FRAGMENT_STRIDE, 11'd1);
    write_register(REG_FILE_COUNT, 11'd1024);
    send_fragment(10'd682, 7'd127, 10'd512, 17'd65536, 10'd512);
    send_fragment(10'd682, 7'd0, 10'd256, 17'd65536, 10'd256);
    send_fragment(10'd682, 7'd42, 10'd1, 17'd1, 10'd1);
    wait_results_drained();
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    sender_mode = 0;
    recv_mode = 0;
    hold_cycles = 300;
    send_file(40, 1023);
    wait_results_drained();
  endtask

  // Randomized transfers over several register settings.
  task automatic test_random_transfer();
    int goal;
    int count;
    logic [CFG_W-1:0] stride;
    for (int phase = 0; phase < 4; phase++) begin
      sender_mode = (phase == 0) ? 0 : 1;
      recv_mode = (phase == 0) ? 0 : 1;
      case (phase)
        0: stride = CFG_W'($urandom_range(1, 1024));
        1: stride = 11'd1;
        2: stride = 11'd2047;
        default: stride = 11'd1024;
      endcase
      count = (phase == 3) ? 1024 : done_count + $urandom_range(1, 30);
      if (count > 1024) count = 1024;
      write_register(REG_FRAGMENT_STRIDE, stride);
      write_register(REG_FILE_COUNT, CFG_W'(count));
      // One file that fills every slot, with fragment lengths up to the longest.
      if (phase == 1) send_file(128, 1023);
      goal = useful_items + 140;
      while (useful_items < goal) begin
        if ($urandom_range(0, 4) != 0)
          send_file(($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6),
                    1023);
        else
          send_noise();
      end
      wait_results_drained();
    end
  endtask

  // Result side: long hold-offs on request, otherwise random stalls unless recv_mode is zero.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_cycles > 0) begin
      pop <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else if (pop_pause > 0) begin
      pop <= 1'b0;
      pop_pause = pop_pause - 1;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 3) == 0) pop_pause = pick_gap(recv_mode);
    end
  end

  // Compare each result transaction with the oldest predicted verdict.
  always @(posedge clk) begin : result_check
    frt_result_t want;
    if (!rst && pop && !empty) begin
      if (predicted_verdicts.size() == 0) begin
        report_mismatch("unexpected result", 32'(file_echo), 32'd0);
      end else begin
        want = predicted_verdicts.pop_front();
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (file_echo !== want.file_echo)
          report_mismatch("file_echo", 32'(file_echo), 32'(want.file_echo));
        if (buffer_offset !== want.buffer_offset)
          report_mismatch("buffer_offset", 32'(buffer_offset), 32'(want.buffer_offset));
        if (bytes_received !== want.bytes_received)
          report_mismatch("bytes_received", 32'(bytes_received), 32'(want.bytes_received));
        if (files_done !== want.files_done)
          report_mismatch("files_done", 32'(files_done), 32'(want.files_done));
        if (all_done !== want.all_done)
          report_mismatch("all_done", 32'(all_done), 32'(want.all_done));
      end
    end
  end

  // Reset, run the tests in turn, then give the verdict.
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_backpressure();
    test_random_transfer();
    wait_results_drained();
    if (mismatch_count == 0 && predicted_verdicts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
